FILE: sv/wgps_pkg.sv
`timescale 1ns / 1ps
package wgps_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int RING_COUNT    = 10;

  localparam int ATAN_LEN    = 24;
  localparam int STAGE_COUNT = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int DARK_W  = 8;
  localparam logic [DARK_W-1:0] DARK_RESET = DARK_W'(32);
  localparam int V_W     = 16;

  // vectoring
  localparam int VEC_FRAC = 14;
  localparam int VEC_W    = COORD_BITS + VEC_FRAC + 3;
  localparam int Z_W      = 18;

  // radius
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int ROOT_W = COORD_BITS + 9;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int RAD_FRAC = 16;

  // v / 150, biased to a non-negative dividend
  localparam int DIV_N_W    = 30;
  localparam int DIV_STAGES = DIV_N_W / 2;
  localparam int DIV_R_W    = 8;
  localparam int Q_W        = 22;
  localparam int DIVISOR    = 150;
  localparam int DIV_BIAS   = 44;
  localparam int DIV_C      = 1789570;
  localparam int V_SHIFT    = 13;

  localparam int FRONT_A   = (STAGE_COUNT > ROOT_W) ? STAGE_COUNT : ROOT_W;
  localparam int FRONT_LAT = (FRONT_A > DIV_STAGES) ? FRONT_A : DIV_STAGES;

  // phase
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int TWO_PI_Q13  = 2 * PI_Q13;
  localparam int PH_W        = 24;
  localparam int WRAP_STEPS  = 7;
  localparam int BIAS_WRAPS  = 64;
  localparam int PH_BIAS     = BIAS_WRAPS * TWO_PI_Q13 - DIV_C;

  // sine
  localparam int R_W      = 18;
  localparam int S_W      = 16;
  localparam int GAIN_Q14 = 9949;
  localparam int ONE_Q14  = 16384;
  localparam int SIN_LAT  = STAGE_COUNT + 5;

  // shading
  localparam int COEF_Q14    = 18022;
  localparam int OFF_SHIFT   = 20;
  localparam int OFF_PW      = S_W + 16;
  localparam int O_W         = 10;
  localparam int SUM_W       = ROOT_W + 2;
  localparam int T_W         = COORD_BITS + 1;
  localparam int RECIP10     = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int SHADE_LAT   = 4;

  localparam int TOTAL_LAT = 1 + FRONT_LAT + SIN_LAT + SHADE_LAT;

  typedef struct packed {
    logic                  vld;
    logic                  wzero;
    logic signed [Z_W-1:0] z;
  } vec_res_t;

  function automatic logic signed [Z_W-1:0] atan_q13(input int i);
    case (i)
      0:       atan_q13 = Z_W'(6434);
      1:       atan_q13 = Z_W'(3798);
      2:       atan_q13 = Z_W'(2007);
      3:       atan_q13 = Z_W'(1019);
      4:       atan_q13 = Z_W'(511);
      5:       atan_q13 = Z_W'(256);
      6:       atan_q13 = Z_W'(128);
      7:       atan_q13 = Z_W'(64);
      8:       atan_q13 = Z_W'(32);
      9:       atan_q13 = Z_W'(16);
      10:      atan_q13 = Z_W'(8);
      11:      atan_q13 = Z_W'(4);
      12:      atan_q13 = Z_W'(2);
      13:      atan_q13 = Z_W'(1);
      default: atan_q13 = '0;
    endcase
  endfunction

endpackage

FILE: sv/wood_grain_pixel_shade_unit.sv
`timescale 1ns / 1ps
// Wood grain pixel shader.
// Input: a transaction is taken on each rising edge with start high and busy
// low; busy is always low, so one point (u, v, w) and a base colour can be
// issued every cycle.
// Output: out_valid is high for one cycle with out_shaded_color; the receiver
// cannot stall, results leave in issue order.
// Pipeline: input register, front section, sine section, shading stages. The
// front section is set by the longest of the radius square root (one root bit
// a stage), the v/150 divider (two bits a stage) and the vectoring CORDIC;
// the back section by the phase wrap, rotation CORDIC and ring decode.
// Throughput: one transaction per cycle.
// Configuration: cfg_we writes cfg_wdata into the darken amount; write only
// while no transaction is in flight.
// Reset: synchronous rst_n clears all valid bits, discards work in flight and
// sets the darken amount to 32.
module wood_grain_pixel_shade_unit
  import wgps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_coord_u,
  input  logic signed [V_W-1:0]        in_coord_v,
  input  logic signed [COORD_BITS-1:0] in_coord_w,
  input  logic [COLOR_W-1:0]           in_base_color,
  output logic                         out_valid,
  output logic [COLOR_W-1:0]           out_shaded_color,
  input  logic                         cfg_we,
  input  logic [DARK_W-1:0]            cfg_wdata
);

  localparam int COL_DLY = FRONT_LAT + SIN_LAT;

  logic [DARK_W-1:0] dark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r <= DARK_RESET;
    end else if (cfg_we) begin
      dark_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  logic signed [2*COORD_BITS-1:0] uu, ww;
  logic [SQ_W-1:0]                sq;
  logic signed [COORD_BITS:0]     ue, we, xv, yv;
  logic                           wneg;
  logic signed [VEC_W-1:0]        x_nxt, y_nxt;
  logic signed [Z_W-1:0]          z_nxt;
  logic [DIV_N_W-1:0]             n_nxt;

  always_comb begin
    uu    = in_coord_u * in_coord_u;
    ww    = in_coord_w * in_coord_w;
    sq    = SQ_W'(uu) + SQ_W'(ww);
    ue    = (COORD_BITS+1)'(in_coord_u);
    we    = (COORD_BITS+1)'(in_coord_w);
    wneg  = in_coord_w[COORD_BITS-1];
    xv    = wneg ? -we : we;
    yv    = wneg ? -ue : ue;
    x_nxt = VEC_W'(xv) <<< VEC_FRAC;
    y_nxt = VEC_W'(yv) <<< VEC_FRAC;
    if (!wneg) begin
      z_nxt = '0;
    end else if (in_coord_u[COORD_BITS-1]) begin
      z_nxt = -Z_W'(PI_Q13);
    end else begin
      z_nxt = Z_W'(PI_Q13);
    end
    n_nxt = DIV_N_W'({~in_coord_v[V_W-1], in_coord_v[V_W-2:0], V_SHIFT'(0)})
            + DIV_N_W'(DIV_BIAS);
  end

  logic                    vld0_r, wz0_r;
  logic signed [VEC_W-1:0] x0_r, y0_r;
  logic signed [Z_W-1:0]   z0_r;
  logic [RAD_W-1:0]        rad0_r;
  logic [DIV_N_W-1:0]      n0_r;
  logic [COLOR_W-1:0]      col0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    wz0_r  <= (in_coord_w == '0);
    x0_r   <= x_nxt;
    y0_r   <= y_nxt;
    z0_r   <= z_nxt;
    rad0_r <= RAD_W'({sq, RAD_FRAC'(0)});
    n0_r   <= n_nxt;
    col0_r <= in_base_color;
  end

  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    quo;
  vec_res_t          vres;

  wgps_sqrt u_sqrt (
    .clk      (clk),
    .in_rad   (rad0_r),
    .out_root (root)
  );

  wgps_div u_div (
    .clk   (clk),
    .in_n  (n0_r),
    .out_q (quo)
  );

  wgps_vec u_vec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld0_r),
    .in_wzero (wz0_r),
    .in_x     (x0_r),
    .in_y     (y0_r),
    .in_z     (z0_r),
    .out_res  (vres)
  );

  logic                  s_vld;
  logic signed [S_W-1:0] s_val;

  wgps_sine u_sine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vec  (vres),
    .in_q    (quo),
    .out_vld (s_vld),
    .out_s   (s_val)
  );

  logic [ROOT_W-1:0]  r8_dly_r  [SIN_LAT];
  logic [COLOR_W-1:0] col_dly_r [COL_DLY];

  always_ff @(posedge clk) begin
    r8_dly_r[0]  <= root;
    col_dly_r[0] <= col0_r;
    for (int i = 1; i < SIN_LAT; i++) begin
      r8_dly_r[i] <= r8_dly_r[i-1];
    end
    for (int i = 1; i < COL_DLY; i++) begin
      col_dly_r[i] <= col_dly_r[i-1];
    end
  end

  wgps_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s_vld),
    .in_s      (s_val),
    .in_r8     (r8_dly_r[SIN_LAT-1]),
    .in_color  (col_dly_r[COL_DLY-1]),
    .in_dark   (dark_r),
    .out_vld   (out_valid),
    .out_color (out_shaded_color)
  );

`ifndef SYNTHESIS
  a_result_has_issue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching transaction");

  a_only_darkens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shaded_color[7:0] <= $past(in_base_color[7:0], TOTAL_LAT))
                  && (out_shaded_color[15:8] <= $past(in_base_color[15:8], TOTAL_LAT))
                  && (out_shaded_color[23:16] <= $past(in_base_color[23:16], TOTAL_LAT)))
    else $error("shaded channel brighter than base");
`endif

endmodule

FILE: sv/wgps_sqrt.sv
`timescale 1ns / 1ps
module wgps_sqrt
  import wgps_pkg::*;
(
  input  logic              clk,
  input  logic [RAD_W-1:0]  in_rad,
  output logic [ROOT_W-1:0] out_root
);

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r  [FRONT_LAT];
  logic [REM_W-1:0]  rem_r  [FRONT_LAT];
  logic [ROOT_W-1:0] root_r [FRONT_LAT];

  for (genvar k = 0; k < FRONT_LAT; k++) begin : g_st
    logic [RAD_W-1:0]  rad_s;
    logic [REM_W-1:0]  rem_s;
    logic [ROOT_W-1:0] root_s;
    logic [RAD_W-1:0]  rad_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_s  = in_rad;
      assign rem_s  = '0;
      assign root_s = '0;
    end else begin : g_next
      assign rad_s  = rad_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign root_s = root_r[k-1];
    end

    always_comb begin
      cand  = {rem_s, rad_s[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({root_s, 2'b01});
      if (k < ROOT_W) begin
        rad_nxt = rad_s << 2;
        if (cand >= trial) begin
          rem_nxt  = REM_W'(cand - trial);
          root_nxt = {root_s[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(cand);
          root_nxt = {root_s[ROOT_W-2:0], 1'b0};
        end
      end else begin
        rad_nxt  = rad_s;
        rem_nxt  = rem_s;
        root_nxt = root_s;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= rad_nxt;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
    end
  end

  assign out_root = root_r[FRONT_LAT-1];

endmodule

FILE: sv/wgps_div.sv
`timescale 1ns / 1ps
module wgps_div
  import wgps_pkg::*;
(
  input  logic               clk,
  input  logic [DIV_N_W-1:0] in_n,
  output logic [Q_W-1:0]     out_q
);

  logic [DIV_N_W-1:0] n_r   [FRONT_LAT];
  logic [DIV_R_W-1:0] rem_r [FRONT_LAT];
  logic [Q_W-1:0]     q_r   [FRONT_LAT];

  for (genvar k = 0; k < FRONT_LAT; k++) begin : g_st
    logic [DIV_N_W-1:0] n_s;
    logic [DIV_R_W-1:0] rem_s;
    logic [Q_W-1:0]     q_s;
    logic [DIV_N_W-1:0] n_nxt;
    logic [DIV_R_W-1:0] rem_nxt;
    logic [Q_W-1:0]     q_nxt;
    logic [DIV_R_W:0]   t;

    if (k == 0) begin : g_first
      assign n_s   = in_n;
      assign rem_s = '0;
      assign q_s   = '0;
    end else begin : g_next
      assign n_s   = n_r[k-1];
      assign rem_s = rem_r[k-1];
      assign q_s   = q_r[k-1];
    end

    // two quotient bits a stage
    always_comb begin
      t       = '0;
      n_nxt   = n_s;
      rem_nxt = rem_s;
      q_nxt   = q_s;
      if (k < DIV_STAGES) begin
        for (int j = 0; j < 2; j++) begin
          t     = {rem_nxt, n_nxt[DIV_N_W-1]};
          n_nxt = n_nxt << 1;
          if (t >= (DIV_R_W+1)'(DIVISOR)) begin
            t     = t - (DIV_R_W+1)'(DIVISOR);
            q_nxt = {q_nxt[Q_W-2:0], 1'b1};
          end else begin
            q_nxt = {q_nxt[Q_W-2:0], 1'b0};
          end
          rem_nxt = t[DIV_R_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      n_r[k]   <= n_nxt;
      rem_r[k] <= rem_nxt;
      q_r[k]   <= q_nxt;
    end
  end

  assign out_q = q_r[FRONT_LAT-1];

endmodule

FILE: sv/wgps_vec.sv
`timescale 1ns / 1ps
module wgps_vec
  import wgps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic                  in_wzero,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic signed [Z_W-1:0]   in_z,
  output vec_res_t              out_res
);

  logic                  vld_r [FRONT_LAT];
  logic                  wz_r  [FRONT_LAT];
  logic signed [VEC_W-1:0] x_r [FRONT_LAT];
  logic signed [VEC_W-1:0] y_r [FRONT_LAT];
  logic signed [Z_W-1:0]   z_r [FRONT_LAT];

  for (genvar k = 0; k < FRONT_LAT; k++) begin : g_st
    logic                  vld_s;
    logic                  wz_s;
    logic signed [VEC_W-1:0] x_s, y_s, x_nxt, y_nxt;
    logic signed [Z_W-1:0]   z_s, z_nxt;

    if (k == 0) begin : g_first
      assign vld_s = in_vld;
      assign wz_s  = in_wzero;
      assign x_s   = in_x;
      assign y_s   = in_y;
      assign z_s   = in_z;
    end else begin : g_next
      assign vld_s = vld_r[k-1];
      assign wz_s  = wz_r[k-1];
      assign x_s   = x_r[k-1];
      assign y_s   = y_r[k-1];
      assign z_s   = z_r[k-1];
    end

    always_comb begin
      if (k >= STAGE_COUNT) begin
        x_nxt = x_s;
        y_nxt = y_s;
        z_nxt = z_s;
      end else if (!y_s[VEC_W-1]) begin
        x_nxt = x_s + (y_s >>> k);
        y_nxt = y_s - (x_s >>> k);
        z_nxt = z_s + atan_q13(k);
      end else begin
        x_nxt = x_s - (y_s >>> k);
        y_nxt = y_s + (x_s >>> k);
        z_nxt = z_s - atan_q13(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      wz_r[k] <= wz_s;
      x_r[k]  <= x_nxt;
      y_r[k]  <= y_nxt;
      z_r[k]  <= z_nxt;
    end
  end

  assign out_res.vld   = vld_r[FRONT_LAT-1];
  assign out_res.wzero = wz_r[FRONT_LAT-1];
  assign out_res.z     = z_r[FRONT_LAT-1];

endmodule

FILE: sv/wgps_sine.sv
`timescale 1ns / 1ps
module wgps_sine
  import wgps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  vec_res_t              in_vec,
  input  logic [Q_W-1:0]        in_q,
  output logic                  out_vld,
  output logic signed [S_W-1:0] out_s
);

  localparam int WRAP_HI = WRAP_STEPS / 2;

  logic                p0_vld_r, p1_vld_r, p2_vld_r, p3_vld_r;
  logic [PH_W-1:0]     ph_r, m1_r, m2_r;
  logic signed [Z_W-1:0] p3_z_r;
  logic [PH_W-1:0]     ph_nxt, m1_nxt, m2_nxt;
  logic signed [Z_W-1:0] z_eff, p3_nxt;
  logic signed [PH_W-1:0] z_ext;

  // phase = 20*z + v/150, biased positive
  always_comb begin
    z_eff  = in_vec.wzero ? Z_W'(HALF_PI_Q13) : in_vec.z;
    z_ext  = PH_W'(z_eff);
    ph_nxt = PH_W'(z_ext <<< 4) + PH_W'(z_ext <<< 2) + PH_W'(in_q) + PH_W'(PH_BIAS);
  end

  always_comb begin
    m1_nxt = ph_r;
    for (int j = WRAP_STEPS - 1; j >= WRAP_HI; j--) begin
      if (m1_nxt >= PH_W'(TWO_PI_Q13 << j)) begin
        m1_nxt = m1_nxt - PH_W'(TWO_PI_Q13 << j);
      end
    end
  end

  always_comb begin
    m2_nxt = m1_r;
    for (int j = WRAP_HI - 1; j >= 0; j--) begin
      if (m2_nxt >= PH_W'(TWO_PI_Q13 << j)) begin
        m2_nxt = m2_nxt - PH_W'(TWO_PI_Q13 << j);
      end
    end
  end

  // into [-pi, pi), then fold to [-pi/2, pi/2]
  always_comb begin
    p3_nxt = $signed(Z_W'(m2_r));
    if (p3_nxt >= Z_W'(PI_Q13)) begin
      p3_nxt = p3_nxt - Z_W'(TWO_PI_Q13);
    end
    if (p3_nxt > Z_W'(HALF_PI_Q13)) begin
      p3_nxt = Z_W'(PI_Q13) - p3_nxt;
    end else if (p3_nxt < -Z_W'(HALF_PI_Q13)) begin
      p3_nxt = -Z_W'(PI_Q13) - p3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= in_vec.vld;
      p1_vld_r <= p0_vld_r;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ph_r   <= ph_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    p3_z_r <= p3_nxt;
  end

  logic                  vld_r [STAGE_COUNT];
  logic signed [R_W-1:0] x_r   [STAGE_COUNT];
  logic signed [R_W-1:0] y_r   [STAGE_COUNT];
  logic signed [Z_W-1:0] z_r   [STAGE_COUNT];

  for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_rot
    logic                  vld_s;
    logic signed [R_W-1:0] x_s, y_s, x_nxt, y_nxt;
    logic signed [Z_W-1:0] z_s, z_nxt;

    if (k == 0) begin : g_first
      assign vld_s = p3_vld_r;
      assign x_s   = R_W'(GAIN_Q14);
      assign y_s   = '0;
      assign z_s   = p3_z_r;
    end else begin : g_next
      assign vld_s = vld_r[k-1];
      assign x_s   = x_r[k-1];
      assign y_s   = y_r[k-1];
      assign z_s   = z_r[k-1];
    end

    always_comb begin
      if (!z_s[Z_W-1]) begin
        x_nxt = x_s - (y_s >>> k);
        y_nxt = y_s + (x_s >>> k);
        z_nxt = z_s - atan_q13(k);
      end else begin
        x_nxt = x_s + (y_s >>> k);
        y_nxt = y_s - (x_s >>> k);
        z_nxt = z_s + atan_q13(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k] <= x_nxt;
      y_r[k] <= y_nxt;
      z_r[k] <= z_nxt;
    end
  end

  logic                  s_vld_r;
  logic signed [S_W-1:0] s_r, s_nxt;
  logic signed [R_W-1:0] y_fin;

  always_comb begin
    y_fin = y_r[STAGE_COUNT-1];
    if (y_fin > R_W'(ONE_Q14)) begin
      s_nxt = S_W'(ONE_Q14);
    end else if (y_fin < -R_W'(ONE_Q14)) begin
      s_nxt = -S_W'(ONE_Q14);
    end else begin
      s_nxt = S_W'(y_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= vld_r[STAGE_COUNT-1];
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign out_vld = s_vld_r;
  assign out_s   = s_r;

endmodule

FILE: sv/wgps_shade.sv
`timescale 1ns / 1ps
module wgps_shade
  import wgps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic signed [S_W-1:0] in_s,
  input  logic [ROOT_W-1:0]     in_r8,
  input  logic [COLOR_W-1:0]    in_color,
  input  logic [DARK_W-1:0]     in_dark,
  output logic                  out_vld,
  output logic [COLOR_W-1:0]    out_color
);

  function automatic logic [CH_W-1:0] darken(input logic [CH_W-1:0] ch,
                                             input logic [DARK_W-1:0] amt);
    darken = (ch > amt) ? CH_W'(ch - amt) : '0;
  endfunction

  logic                  h0_vld_r, h1_vld_r, h2_vld_r, h3_vld_r;
  logic signed [O_W-1:0] off_r;
  logic [ROOT_W-1:0]     r8_r;
  logic [COLOR_W-1:0]    col0_r, col1_r, col2_r, col3_r;
  logic [T_W-1:0]        t1_r, t2_r, q2_r;
  logic                  neg1_r, neg2_r;

  logic signed [OFF_PW-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic [T_W-1:0]           t_nxt;
  logic                     neg_nxt;
  logic [T_W+15:0]          rprod;
  logic [T_W-1:0]           ring;
  logic [DARK_W-1:0]        amt;
  logic [COLOR_W-1:0]       col_nxt;

  assign prod = OFF_PW'(in_s) * OFF_PW'(COEF_Q14);

  // truncate toward zero; below -255 is flagged negative and gets no darkening
  always_comb begin
    sum     = $signed(SUM_W'({1'b0, r8_r})) + SUM_W'(off_r);
    neg_nxt = (sum < -255);
    t_nxt   = sum[SUM_W-1] ? '0 : T_W'(sum >>> 8);
  end

  assign rprod = (T_W+16)'(t1_r) * (T_W+16)'(RECIP10);

  always_comb begin
    ring = t2_r - T_W'(q2_r * RING_COUNT);
    amt  = '0;
    if (!neg2_r) begin
      if (ring == '0) begin
        amt = in_dark >> 1;
      end else if (ring inside {T_W'(1), T_W'(2), T_W'(3)}) begin
        amt = in_dark;
      end
    end
    col_nxt = {darken(col2_r[23:16], amt), darken(col2_r[15:8], amt),
               darken(col2_r[7:0], amt)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_vld_r <= 1'b0;
      h1_vld_r <= 1'b0;
      h2_vld_r <= 1'b0;
      h3_vld_r <= 1'b0;
    end else begin
      h0_vld_r <= in_vld;
      h1_vld_r <= h0_vld_r;
      h2_vld_r <= h1_vld_r;
      h3_vld_r <= h2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= O_W'(prod >>> OFF_SHIFT);
    r8_r   <= in_r8;
    col0_r <= in_color;
    t1_r   <= t_nxt;
    neg1_r <= neg_nxt;
    col1_r <= col0_r;
    t2_r   <= t1_r;
    q2_r   <= T_W'(rprod >> RECIP_SHIFT);
    neg2_r <= neg1_r;
    col2_r <= col1_r;
    col3_r <= col_nxt;
  end

  assign out_vld   = h3_vld_r;
  assign out_color = col3_r;

endmodule

FILE: test/tb_wood_grain_pixel_shade_unit.sv
`timescale 1ns / 1ps
module tb_wood_grain_pixel_shade_unit;
  import wgps_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = TOTAL_LAT + 20;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_coord_u;
  logic signed [V_W-1:0]        in_coord_v;
  logic signed [COORD_BITS-1:0] in_coord_w;
  logic [COLOR_W-1:0]           in_base_color;
  logic                         out_valid;
  logic [COLOR_W-1:0]           out_shaded_color;
  logic                         cfg_we;
  logic [DARK_W-1:0]            cfg_wdata;

  logic [COLOR_W-1:0] shade_q[$];
  logic [DARK_W-1:0]  darken_amt;
  int                 err_count;
  int                 sent_count;
  int                 got_count;
  int                 idle_pct;
  int                 stall_cycles;

  wood_grain_pixel_shade_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coord_u(in_coord_u), .in_coord_v(in_coord_v), .in_coord_w(in_coord_w),
    .in_base_color(in_base_color), .out_valid(out_valid),
    .out_shaded_color(out_shaded_color), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint shr_floor(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint div_floor(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint root_int(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 3000000;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[14];
    tbl = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 14) ? tbl[i] : 0;
  endfunction

  function automatic logic [COLOR_W-1:0] grain_shade(logic signed [COORD_BITS-1:0] cu,
      logic signed [V_W-1:0] cv, logic signed [COORD_BITS-1:0] cw,
      logic [COLOR_W-1:0] col, logic [DARK_W-1:0] amt_cfg);
    longint u, v, w, x, y, z, nx, r8, ph, p, s, sum, t, amt;
    logic [CH_W-1:0] ch[3];
    logic [COLOR_W-1:0] res;
    u = cu;
    v = cv;
    w = cw;
    r8 = root_int((u * u + w * w) * 65536);
    if (w == 0) begin
      z = HALF_PI_Q13;
    end else begin
      if (w < 0) begin
        x = -w * 16384;
        y = -u * 16384;
        z = (u >= 0) ? PI_Q13 : -PI_Q13;
      end else begin
        x = w * 16384;
        y = u * 16384;
        z = 0;
      end
      for (int i = 0; i < STAGE_COUNT; i++) begin
        if (y >= 0) begin
          nx = x + shr_floor(y, i);
          y = y - shr_floor(x, i);
          z += atan_entry(i);
        end else begin
          nx = x - shr_floor(y, i);
          y = y + shr_floor(x, i);
          z -= atan_entry(i);
        end
        x = nx;
      end
    end
    ph = 20 * z + div_floor(v * 8192, 150);
    p = ph - div_floor(ph, TWO_PI_Q13) * TWO_PI_Q13;
    if (p >= PI_Q13) p -= TWO_PI_Q13;
    if (p > HALF_PI_Q13) p = PI_Q13 - p;
    else if (p < -HALF_PI_Q13) p = -PI_Q13 - p;
    x = GAIN_Q14;
    y = 0;
    z = p;
    for (int i = 0; i < STAGE_COUNT; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= atan_entry(i);
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += atan_entry(i);
      end
      x = nx;
    end
    s = (y > ONE_Q14) ? ONE_Q14 : ((y < -ONE_Q14) ? -ONE_Q14 : y);
    sum = r8 + shr_floor(s * COEF_Q14, 20);
    t = (sum >= 0) ? (sum >> 8) : -((-sum) >> 8);
    amt = 0;
    if (t >= 0) begin
      if (t % RING_COUNT == 0) amt = amt_cfg / 2;
      else if (t % RING_COUNT <= 3) amt = amt_cfg;
    end
    ch[0] = col[7:0];
    ch[1] = col[15:8];
    ch[2] = col[23:16];
    for (int k = 0; k < 3; k++)
      ch[k] = (ch[k] > amt) ? ch[k] - amt[CH_W-1:0] : '0;
    res = {ch[2], ch[1], ch[0]};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [COLOR_W-1:0] got,
      logic [COLOR_W-1:0] exp_val);
    $display("mismatch %s: shaded_color got %06h exp %06h", what, got, exp_val);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_count++;
      if (shade_q.size() == 0) report_mismatch("unexpected", out_shaded_color, '0);
      else if (shade_q[0] !== out_shaded_color) begin
        report_mismatch("field", out_shaded_color, shade_q[0]);
        void'(shade_q.pop_front());
      end else void'(shade_q.pop_front());
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_pixel(logic signed [COORD_BITS-1:0] cu, logic signed [V_W-1:0] cv,
      logic signed [COORD_BITS-1:0] cw, logic [COLOR_W-1:0] col);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_coord_u    <= cu;
    in_coord_v    <= cv;
    in_coord_w    <= cw;
    in_base_color <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    shade_q.push_back(grain_shade(cu, cv, cw, col, darken_amt));
    sent_count++;
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_darken(logic [DARK_W-1:0] val);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    darken_amt = val;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
    return COORD_BITS'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic test_directed();
    logic signed [COORD_BITS-1:0] cmax, cmin;
    cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
    cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
    idle_pct = 0;
    send_pixel('0, '0, '0, 24'hFFFFFF);
    send_pixel(COORD_BITS'(12), 16'sh7FFF, '0, 24'h808080);
    send_pixel(COORD_BITS'(-12), 16'sh8000, '0, 24'h102030);
    send_pixel(cmax, 16'sh7FFF, cmax, 24'hFFFFFF);
    send_pixel(cmin, 16'sh8000, cmin, 24'h000000);
    send_pixel(cmin, '0, cmax, 24'hFF00FF);
    send_pixel(cmax, V_W'(-1), cmin, 24'h00FF00);
    send_pixel('0, '0, COORD_BITS'(-5), 24'h0F0F0F);
    send_pixel(COORD_BITS'(3), '0, COORD_BITS'(-4), 24'h1F1F1F);
    send_pixel(COORD_BITS'(-3), '0, COORD_BITS'(-4), 24'hFFFFFF);
    send_pixel(COORD_BITS'(1), '0, COORD_BITS'(1), 24'h202020);
    send_pixel('0, '0, COORD_BITS'(1), 24'h101010);
    for (int r = 0; r < 12; r++)
      send_pixel('0, V_W'(r), COORD_BITS'(r), 24'hC0C0C0);
  endtask

  task automatic test_darken_setting(logic [DARK_W-1:0] amt, int n);
    write_darken(amt);
    idle_pct = 36;
    for (int i = 0; i < n; i++)
      send_pixel(rand_coord(($urandom_range(3) == 0) ? 2048 : 40), 16'($urandom),
        rand_coord(($urandom_range(3) == 0) ? 2048 : 40), 24'($urandom));
  endtask

  task automatic test_back_to_back(int n);
    idle_pct = 0;
    for (int i = 0; i < n; i++)
      send_pixel(rand_coord(2048), 16'($urandom), rand_coord(2048), 24'($urandom));
  endtask

  initial begin
    err_count = 0;
    sent_count = 0;
    got_count = 0;
    idle_pct = 0;
    stall_cycles = 0;
    darken_amt = DARK_RESET;
    rst_n = 1'b0;
    start = 1'b0;
    in_coord_u = '0;
    in_coord_v = '0;
    in_coord_w = '0;
    in_base_color = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_darken_setting(DARK_RESET, 300);
    test_darken_setting(8'd0, 250);
    test_darken_setting(8'd255, 300);
    test_back_to_back(200);
    test_darken_setting(8'd1, 200);
    test_darken_setting(8'($urandom), 370);
    quiesce();
    $display("covered %0d pixels over several darken settings, %0d results checked",
      sent_count, got_count);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
